### design/pidpi_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the PID block.
// Used by every module of the design; depends on nothing else.
`timescale 1ns / 1ps

package pidpi_pkg;

   // Word format: signed, FRAC_BITS fraction bits.
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam value_type VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Configuration register indexes.
   localparam int REG_COUNT       = 7;
   localparam int CSR_INDEX_WIDTH = $clog2(REG_COUNT);
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_TARGET_VALUE = CSR_INDEX_WIDTH'(0);
   localparam csr_index_type REG_GAIN_PROP    = CSR_INDEX_WIDTH'(1);
   localparam csr_index_type REG_GAIN_INTEG   = CSR_INDEX_WIDTH'(2);
   localparam csr_index_type REG_GAIN_DERIV   = CSR_INDEX_WIDTH'(3);
   localparam csr_index_type REG_UPPER_LIMIT  = CSR_INDEX_WIDTH'(4);
   localparam csr_index_type REG_LOWER_LIMIT  = CSR_INDEX_WIDTH'(5);
   localparam csr_index_type REG_LOOP_FORM    = CSR_INDEX_WIDTH'(6);

   typedef enum logic {
      CMD_PROCESS = 1'b0,
      CMD_CLEAR   = 1'b1
   } cmd_type;

   typedef enum logic {
      FORM_POSITION    = 1'b0,
      FORM_INCREMENTAL = 1'b1
   } form_type;

   typedef struct packed {
      cmd_type   cmd;
      value_type measured_value;
   } req_type;

   typedef struct packed {
      value_type drive_value;
      logic      limited;
   } rsp_type;

   typedef struct packed {
      value_type target_value;
      value_type gain_prop;
      value_type gain_integ;
      value_type gain_deriv;
      value_type upper_limit;
      value_type lower_limit;
      form_type  loop_form;
   } cfg_type;

   typedef struct packed {
      value_type prev_error;
      value_type prev_prev_error;
      value_type integ_sum;
      value_type prev_drive;
   } state_type;

   // Saturating add.
   function automatic value_type sat_add(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   // Saturating subtract.
   function automatic value_type sat_sub(value_type a, value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   // Fixed-point product: exact, floored by the fraction shift, then saturated.
   function automatic value_type qmul(value_type a, value_type b);
      logic signed [PROD_WIDTH-1:0]  prod;
      logic signed [SHIFT_WIDTH-1:0] shifted;
      logic [SHIFT_WIDTH-VALUE_WIDTH:0] top;
      prod    = a * b;
      shifted = prod[PROD_WIDTH-1:FRAC_BITS];
      top     = shifted[SHIFT_WIDTH-1:VALUE_WIDTH-1];
      if ((&top) || !(|top)) begin
         return shifted[VALUE_WIDTH-1:0];
      end
      return shifted[SHIFT_WIDTH-1] ? VMIN : VMAX;
   endfunction

   // Clamp to the limits; the upper limit is tested first.
   function automatic rsp_type clamp(value_type v, value_type upper, value_type lower);
      rsp_type r;
      if (v > upper) begin
         r.drive_value = upper;
         r.limited     = 1'b1;
      end else if (v < lower) begin
         r.drive_value = lower;
         r.limited     = 1'b1;
      end else begin
         r.drive_value = v;
         r.limited     = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/pidpi_csr.sv
// Configuration registers of the PID block and the history clear on a form write.
// Depends on pidpi_pkg.
`timescale 1ns / 1ps

module pidpi_csr
   import pidpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  value_type     csr_data,
   output cfg_type       cfg,
   output logic          clear_history
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            REG_TARGET_VALUE: cfg_in.target_value = csr_data;
            REG_GAIN_PROP:    cfg_in.gain_prop    = csr_data;
            REG_GAIN_INTEG:   cfg_in.gain_integ   = csr_data;
            REG_GAIN_DERIV:   cfg_in.gain_deriv   = csr_data;
            REG_UPPER_LIMIT:  cfg_in.upper_limit  = csr_data;
            REG_LOWER_LIMIT:  cfg_in.lower_limit  = csr_data;
            REG_LOOP_FORM:    cfg_in.loop_form    = form_type'(csr_data[0]);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_value <= '0;
         cfg_ff.gain_prop    <= '0;
         cfg_ff.gain_integ   <= '0;
         cfg_ff.gain_deriv   <= '0;
         cfg_ff.upper_limit  <= VMAX;
         cfg_ff.lower_limit  <= VMIN;
         cfg_ff.loop_form    <= FORM_POSITION;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg           = cfg_ff;
   assign clear_history = write_en && (csr_index == REG_LOOP_FORM);

endmodule

### design/pidpi_datapath.sv
// One control step of the PID block: error, three gain products, sums and clamp.
// Produces the result and the next history. Depends on pidpi_pkg.
`timescale 1ns / 1ps

module pidpi_datapath
   import pidpi_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type state,
   input  req_type   req,
   output rsp_type   rsp,
   output state_type state_next
);

   value_type err;
   value_type err_diff;
   value_type twice_prev;
   value_type second_diff;
   value_type prod_p;
   value_type prod_i;
   value_type prod_d;
   value_type pd_sum;
   value_type integ_try;
   value_type total;
   value_type fallback;
   value_type delta;
   logic      in_range;
   logic      incremental;

   assign incremental = (cfg.loop_form == FORM_INCREMENTAL);

   // The three multipliers are shared by both forms; only their operands move.
   always_comb begin
      err         = sat_sub(cfg.target_value, req.measured_value);
      err_diff    = sat_sub(err, state.prev_error);
      twice_prev  = sat_add(state.prev_error, state.prev_error);
      second_diff = sat_add(sat_sub(err, twice_prev), state.prev_prev_error);
      prod_p      = qmul(cfg.gain_prop, incremental ? err_diff : err);
      prod_i      = qmul(cfg.gain_integ, err);
      prod_d      = qmul(cfg.gain_deriv, incremental ? second_diff : err_diff);
   end

   always_comb begin
      pd_sum    = sat_add(prod_p, prod_d);
      integ_try = sat_add(state.integ_sum, prod_i);
      total     = sat_add(pd_sum, integ_try);
      fallback  = sat_add(sat_add(prod_p, state.integ_sum), prod_d);
      delta     = sat_add(sat_add(prod_p, prod_i), prod_d);
      in_range  = (total <= cfg.upper_limit) && (total >= cfg.lower_limit);

      state_next = state;
      if (req.cmd == CMD_CLEAR) begin
         state_next      = '0;
         rsp.drive_value = '0;
         rsp.limited     = 1'b0;
      end else if (incremental) begin
         rsp = clamp(sat_add(state.prev_drive, delta), cfg.upper_limit, cfg.lower_limit);
         state_next.prev_prev_error = state.prev_error;
         state_next.prev_error      = err;
         state_next.prev_drive      = rsp.drive_value;
      end else begin
         // Anti-windup: the new integral is kept only when the total fits.
         if (in_range) begin
            rsp.drive_value      = total;
            rsp.limited          = 1'b0;
            state_next.integ_sum = integ_try;
         end else begin
            rsp = clamp(fallback, cfg.upper_limit, cfg.lower_limit);
         end
         state_next.prev_error = err;
         state_next.prev_drive = rsp.drive_value;
      end
   end

endmodule

### design/pid_position_incremental.sv
// Fixed-point PID controller, position or incremental form, with anti-windup.
// An accepted item waits in the input register; its result enters the result register
// once that register is free. Throughput: one item per cycle while results are taken; each
// step runs through the three gain multipliers, the saturating adders and the clamp.
// Reset (synchronous, active high) empties both pipeline registers, zeroes the history
// and restores every configuration register to its reset value.
`timescale 1ns / 1ps

module pid_position_incremental
   import pidpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   // Measurement items in.
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,

   // Drive values out.
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,

   // Configuration writes.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  value_type     csr_data
);

   // Input register: holds the accepted item while the step is computed.
   req_type   req_ff;
   logic      req_valid_ff;
   logic      req_valid_in;

   // Result register: holds the finished item until the consumer takes it,
   // so the input register can still take one item while a result waits.
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Controller history.
   state_type state_ff;
   state_type state_in;

   cfg_type   cfg;
   logic      clear_history;
   rsp_type   step_rsp;
   state_type step_state;
   logic      advance;
   logic      req_accept;

   pidpi_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cfg           (cfg),
      .clear_history (clear_history)
   );

   pidpi_datapath u_datapath (
      .cfg        (cfg),
      .state      (state_ff),
      .req        (req_ff),
      .rsp        (step_rsp),
      .state_next (step_state)
   );

   // The held item moves into the result register whenever that register is
   // empty or is being emptied this cycle; the history updates on the same edge unless a form write clears it.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !req_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      req_valid_in = req_accept || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      state_in     = state_ff;
      if (clear_history) begin
         state_in = '0;
      end else if (advance) begin
         state_in = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A form write leaves the history all zero.
   assert property (@(posedge clock) disable iff (reset)
      clear_history |=> (state_ff == '0))
      else $error("history not cleared after a form write");

   // A clear item yields a zero, unlimited result and zero history.
   assert property (@(posedge clock) disable iff (reset)
      advance && (req_ff.cmd == CMD_CLEAR) |=>
         rsp_valid_ff && (rsp_ff.drive_value == '0) && !rsp_ff.limited && (state_ff == '0))
      else $error("clear item did not zero result and history");

   // The stored last drive value matches the result just produced.
   assert property (@(posedge clock) disable iff (reset)
      advance && !clear_history |=> rsp_valid_ff && (state_ff.prev_drive == rsp_ff.drive_value))
      else $error("stored drive value differs from the result");

   // A limited result sits exactly on one of the limits in force at the step.
   assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.limited |->
         (step_rsp.drive_value == cfg.upper_limit) || (step_rsp.drive_value == cfg.lower_limit))
      else $error("limited result is not on a limit");
`endif

endmodule
